// ===== rtl/frce_pkg.sv =====
package frce_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NumSourcesDef    = 64;
  localparam int unsigned SeqWindowDef     = 256;
  localparam int unsigned DecayExponentDef = 2;
  localparam int unsigned FifoDepthDef     = 2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_OWN_NODE      = 3'd0;
  localparam logic [2:0] REG_OWN_X         = 3'd1;
  localparam logic [2:0] REG_OWN_Y         = 3'd2;
  localparam logic [2:0] REG_BASE_INTERVAL = 3'd3;
  localparam logic [2:0] REG_NEAR_WAIT     = 3'd4;
  localparam logic [2:0] REG_FAR_WAIT      = 3'd5;
  localparam logic [2:0] REG_REACH_METERS  = 3'd6;

  // Input opcodes
  localparam logic [1:0] OP_ARRIVAL      = 2'd0;
  localparam logic [1:0] OP_FIRST_EXPIRY = 2'd1;
  localparam logic [1:0] OP_DECAY_EXPIRY = 2'd2;

  // Per-source wait phase
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_DECAY = 2'd2;

  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_ARM_FIRST = 3'd1,
    ACT_ARM_DECAY = 3'd2,
    ACT_FORWARD   = 3'd3,
    ACT_CANCEL    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ARRIVAL = 2'd1,
    CMD_FIRST   = 2'd2,
    CMD_DECAY   = 2'd3
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR = 3'd0,
    BK_IDLE  = 3'd1,
    BK_EXEC  = 3'd2,
    BK_SQR   = 3'd3,
    BK_MUL   = 3'd4,
    BK_DIV   = 3'd5,
    BK_DECAY = 3'd6,
    BK_OUT   = 3'd7
  } back_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        source;
    logic [15:0]        sequence_req;
    logic [15:0]        hops;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] relay_x;
    logic signed [15:0] relay_y;
    logic [15:0]        jitter;
  } in_item_t;

  typedef struct packed {
    action_e            action;
    logic [5:0]         out_source;
    logic [31:0]        delay_ticks;
    logic [15:0]        out_sequence;
    logic [15:0]        out_hops;
    logic signed [15:0] out_origin_x;
    logic signed [15:0] out_origin_y;
    logic signed [15:0] out_relay_x;
    logic signed [15:0] out_relay_y;
  } out_item_t;

  typedef struct packed {
    logic [5:0]         own_node;
    logic signed [15:0] own_x;
    logic signed [15:0] own_y;
    logic [15:0]        base_interval;
    logic [15:0]        near_wait;
    logic [15:0]        far_wait;
    logic [14:0]        reach_meters;
  } cfg_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    cmd_kind_e          kind;
    logic [15:0]        seq;
    logic [15:0]        hops;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        jitter;
    logic [32:0]        dist2;
  } cmd_t;

  // Per-source record: phase, pending flag and held packet
  typedef struct packed {
    logic [1:0]  phase;
    logic        flag;
    logic [15:0] seq;
    logic [15:0] hops;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } src_rec_t;

endpackage

// ===== rtl/frce_fifo.sv =====
module frce_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = frce_pkg::FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/frce_front.sv =====
module frce_front #(
  parameter int unsigned NUM_SOURCES = frce_pkg::NumSourcesDef,
  parameter int unsigned SEQ_WINDOW  = frce_pkg::SeqWindowDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  frce_pkg::in_item_t             item_i,
  input  frce_pkg::cfg_t                 cfg_i,
  input  logic                           hold_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output frce_pkg::cmd_t                 q_cmd_o,
  output logic [$clog2(NUM_SOURCES)-1:0] q_idx_o,
  output logic [$clog2(SEQ_WINDOW)-1:0]  q_rem_o
);
  import frce_pkg::*;

  localparam int unsigned SrcW     = $clog2(NUM_SOURCES);
  localparam int unsigned SeqW     = $clog2(SEQ_WINDOW);
  localparam logic [31:0] SeqRecip = 32'((64'd1 << 32) / SEQ_WINDOW);
  localparam logic [16:0] SeqWin17 = 17'(SEQ_WINDOW);

  logic               accept, s1_adv, s2_adv;
  logic               s1_vld_q, s2_vld_q;
  logic               src_ok;
  cmd_kind_e          kind;
  logic [47:0]        quo_prod;
  logic [16:0]        dx, dy;
  in_item_t           s1_item_q, s2_item_q;
  cmd_kind_e          s1_kind_q, s2_kind_q;
  logic [SrcW-1:0]    s1_idx_q, s2_idx_q;
  logic signed [16:0] s1_dx_q, s1_dy_q;
  logic [15:0]        s1_quo_q;
  logic signed [33:0] sqx_full, sqy_full;
  logic [31:0]        quo_w;
  logic [15:0]        rem_raw;
  logic [31:0]        s2_sqx_q, s2_sqy_q;
  logic [15:0]        s2_rem_q, rem_c;

  // Stage handshake
  assign s2_adv   = s2_vld_q && !q_full_i;
  assign s1_adv   = s1_vld_q && (!s2_vld_q || s2_adv);
  assign full_o   = hold_i || (s1_vld_q && s2_vld_q && !s2_adv);
  assign accept   = push_i && !full_o;
  assign q_push_o = s2_vld_q;

  // Classify the incoming transaction
  assign src_ok = (item_i.source != 16'd0) && (17'(item_i.source) < 17'(NUM_SOURCES));

  always_comb begin
    kind = CMD_NONE;
    if (src_ok) begin
      case (item_i.opcode)
        OP_ARRIVAL: begin
          if (item_i.source != 16'(cfg_i.own_node)) kind = CMD_ARRIVAL;
        end
        OP_FIRST_EXPIRY: kind = CMD_FIRST;
        OP_DECAY_EXPIRY: kind = CMD_DECAY;
        default:         kind = CMD_NONE;
      endcase
    end
  end

  // Offsets to the last sender and sequence quotient estimate
  assign dx       = {cfg_i.own_x[15], cfg_i.own_x} - {item_i.relay_x[15], item_i.relay_x};
  assign dy       = {cfg_i.own_y[15], cfg_i.own_y} - {item_i.relay_y[15], item_i.relay_y};
  assign quo_prod = 48'(item_i.sequence_req) * 48'(SeqRecip);

  // Squares and raw remainder
  assign sqx_full = 34'(s1_dx_q) * 34'(s1_dx_q);
  assign sqy_full = 34'(s1_dy_q) * 34'(s1_dy_q);
  assign quo_w    = 32'(s1_quo_q) * 32'(SEQ_WINDOW);
  assign rem_raw  = 16'(32'(s1_item_q.sequence_req) - quo_w);

  // Correct the remainder and build the queue entry
  assign rem_c = (17'(s2_rem_q) >= SeqWin17) ? 16'(17'(s2_rem_q) - SeqWin17) : s2_rem_q;

  always_comb begin
    q_cmd_o.kind     = s2_kind_q;
    q_cmd_o.seq      = s2_item_q.sequence_req;
    q_cmd_o.hops     = s2_item_q.hops;
    q_cmd_o.origin_x = s2_item_q.origin_x;
    q_cmd_o.origin_y = s2_item_q.origin_y;
    q_cmd_o.jitter   = s2_item_q.jitter;
    q_cmd_o.dist2    = 33'(s2_sqx_q) + 33'(s2_sqy_q);
  end
  assign q_idx_o = s2_idx_q;
  assign q_rem_o = rem_c[SeqW-1:0];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_q <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
      s1_kind_q <= kind;
      s1_idx_q  <= item_i.source[SrcW-1:0];
      s1_dx_q   <= dx;
      s1_dy_q   <= dy;
      s1_quo_q  <= quo_prod[47:32];
    end
    if (s1_adv) begin
      s2_item_q <= s1_item_q;
      s2_kind_q <= s1_kind_q;
      s2_idx_q  <= s1_idx_q;
      s2_sqx_q  <= sqx_full[31:0];
      s2_sqy_q  <= sqy_full[31:0];
      s2_rem_q  <= rem_raw;
    end
  end

endmodule

// ===== rtl/frce_back.sv =====
module frce_back #(
  parameter int unsigned NUM_SOURCES    = frce_pkg::NumSourcesDef,
  parameter int unsigned SEQ_WINDOW     = frce_pkg::SeqWindowDef,
  parameter int unsigned DECAY_EXPONENT = frce_pkg::DecayExponentDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  frce_pkg::cfg_t                 cfg_i,
  input  logic                           q_empty_i,
  output logic                           q_pop_o,
  input  frce_pkg::cmd_t                 q_cmd_i,
  input  logic [$clog2(NUM_SOURCES)-1:0] q_idx_i,
  input  logic [$clog2(SEQ_WINDOW)-1:0]  q_rem_i,
  input  logic                           o_full_i,
  output logic                           o_push_o,
  output frce_pkg::out_item_t            o_item_o,
  output logic                           clearing_o
);
  import frce_pkg::*;

  localparam int unsigned SrcW       = $clog2(NUM_SOURCES);
  localparam int unsigned SeqW       = $clog2(SEQ_WINDOW);
  localparam int unsigned SeenAw     = SrcW + SeqW;
  localparam int unsigned SeenDepth  = 2 ** SeenAw;
  localparam int unsigned SrcDepth   = 2 ** SrcW;
  localparam logic [4:0]  DivLast    = 5'd15;
  localparam logic [4:0]  DecaySteps = 5'(DECAY_EXPONENT);

  logic     seen_mem [SeenDepth];
  src_rec_t src_mem  [SrcDepth];

  back_state_e       st_q, st_d;
  logic [SeenAw-1:0] clr_q, clr_d;
  logic [4:0]        cnt_q, cnt_d;
  cmd_t              cmd_q;
  logic [SrcW-1:0]   idx_q;
  logic [SeenAw-1:0] addr_q;
  logic              seen_rd_q;
  src_rec_t          rec_q;
  out_item_t         res_q, res_d, fwd_item;
  logic [29:0]       maxd2_q, maxd2_d;
  logic [29:0]       div_r_q, div_r_d, div_rn, d2c;
  logic [15:0]       div_lo_q, div_lo_d;
  logic [31:0]       acc_q, acc_d, decay_w;
  logic              sat_q, sat_d;
  logic              pop, fresh, div_ge;
  logic [30:0]       div_t;
  logic [45:0]       dist_prod;
  logic [47:0]       hop_prod, base_prod;
  logic [15:0]       idx_w, quo;
  logic [5:0]        src6;
  logic              seen_we, seen_wd;
  logic [SeenAw-1:0] seen_wa;
  logic              src_we;
  logic [SrcW-1:0]   src_wa;
  src_rec_t          src_wd;

  assign q_pop_o    = pop;
  assign o_item_o   = res_q;
  assign clearing_o = (st_q == BK_CLEAR);
  assign fresh      = !seen_rd_q;
  assign idx_w      = 16'(idx_q);
  assign src6       = idx_w[5:0];

  // Forwarded packet built from the held record
  always_comb begin
    fwd_item              = '0;
    fwd_item.action       = ACT_FORWARD;
    fwd_item.out_source   = src6;
    fwd_item.out_sequence = rec_q.seq;
    fwd_item.out_hops     = rec_q.hops + 16'd1;
    fwd_item.out_origin_x = rec_q.origin_x;
    fwd_item.out_origin_y = rec_q.origin_y;
    fwd_item.out_relay_x  = cfg_i.own_x;
    fwd_item.out_relay_y  = cfg_i.own_y;
  end

  // Distance wait: clamp, scale, one quotient bit per cycle
  assign d2c       = (cmd_q.dist2 > 33'(maxd2_q)) ? maxd2_q : cmd_q.dist2[29:0];
  assign dist_prod = 46'(cfg_i.far_wait - cfg_i.near_wait) * 46'(d2c);
  assign div_t     = {div_r_q, div_lo_q[15]};
  assign div_ge    = (div_t >= {1'b0, maxd2_q});
  assign div_rn    = div_ge ? 30'(div_t - {1'b0, maxd2_q}) : div_t[29:0];
  assign quo       = {div_lo_q[14:0], div_ge};

  // Decay wait: one multiplication per cycle
  assign hop_prod  = 48'(acc_q) * 48'(rec_q.hops);
  assign base_prod = 48'(acc_q) * 48'(cfg_i.base_interval);
  assign decay_w   = sat_q ? Sat32 :
                     (base_prod > 48'(Sat32)) ? Sat32 : base_prod[31:0];

  // Sequencer
  always_comb begin
    st_d     = st_q;
    clr_d    = clr_q;
    cnt_d    = cnt_q;
    res_d    = res_q;
    maxd2_d  = maxd2_q;
    div_r_d  = div_r_q;
    div_lo_d = div_lo_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    pop      = 1'b0;
    o_push_o = 1'b0;
    seen_we  = 1'b0;
    seen_wa  = addr_q;
    seen_wd  = 1'b1;
    src_we   = 1'b0;
    src_wa   = idx_q;
    src_wd   = rec_q;
    case (st_q)
      BK_CLEAR: begin
        seen_we = 1'b1;
        seen_wa = clr_q;
        seen_wd = 1'b0;
        src_we  = 1'b1;
        src_wa  = clr_q[SrcW-1:0];
        src_wd  = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) st_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop  = 1'b1;
          st_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        res_d = '0;
        st_d  = BK_OUT;
        case (cmd_q.kind)
          CMD_ARRIVAL: begin
            seen_we = fresh;
            if (rec_q.flag) begin
              if (cmd_q.seq == rec_q.seq) begin
                if (cmd_q.hops > rec_q.hops) begin
                  src_we           = 1'b1;
                  src_wd.phase     = PH_IDLE;
                  src_wd.flag      = 1'b0;
                  res_d.action     = ACT_CANCEL;
                  res_d.out_source = src6;
                end
              end else if (cmd_q.seq > rec_q.seq) begin
                src_we          = 1'b1;
                src_wd.seq      = cmd_q.seq;
                src_wd.hops     = cmd_q.hops;
                src_wd.origin_x = cmd_q.origin_x;
                src_wd.origin_y = cmd_q.origin_y;
              end
            end else if (fresh) begin
              src_we           = 1'b1;
              src_wd.phase     = PH_FIRST;
              src_wd.flag      = 1'b1;
              src_wd.seq       = cmd_q.seq;
              src_wd.hops      = cmd_q.hops;
              src_wd.origin_x  = cmd_q.origin_x;
              src_wd.origin_y  = cmd_q.origin_y;
              res_d.action     = ACT_ARM_FIRST;
              res_d.out_source = src6;
              st_d             = BK_SQR;
            end
          end
          CMD_FIRST: begin
            src_we = 1'b1;
            if (!rec_q.flag || rec_q.phase != PH_FIRST) begin
              src_wd.phase = PH_IDLE;
              src_wd.flag  = 1'b0;
            end else if (rec_q.hops == 16'd0) begin
              src_wd.phase = PH_IDLE;
              src_wd.flag  = 1'b0;
              res_d        = fwd_item;
            end else begin
              src_wd.phase = PH_DECAY;
              acc_d        = 32'd1;
              sat_d        = 1'b0;
              cnt_d        = '0;
              st_d         = BK_DECAY;
            end
          end
          CMD_DECAY: begin
            src_we       = 1'b1;
            src_wd.phase = PH_IDLE;
            src_wd.flag  = 1'b0;
            if (rec_q.flag && rec_q.phase == PH_DECAY) res_d = fwd_item;
          end
          default: ;
        endcase
      end
      BK_SQR: begin
        maxd2_d = 30'(cfg_i.reach_meters) * 30'(cfg_i.reach_meters);
        st_d    = BK_MUL;
      end
      BK_MUL: begin
        if (cmd_q.dist2 == '0 || cfg_i.far_wait < cfg_i.near_wait) begin
          res_d.delay_ticks = 32'(cfg_i.far_wait) + 32'(cmd_q.jitter);
          st_d              = BK_OUT;
        end else if (maxd2_q == '0) begin
          res_d.delay_ticks = 32'(cfg_i.near_wait) + 32'(cmd_q.jitter);
          st_d              = BK_OUT;
        end else begin
          div_r_d  = dist_prod[45:16];
          div_lo_d = dist_prod[15:0];
          cnt_d    = '0;
          st_d     = BK_DIV;
        end
      end
      BK_DIV: begin
        div_r_d  = div_rn;
        div_lo_d = quo;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          res_d.delay_ticks = 32'(cfg_i.far_wait - quo) + 32'(cmd_q.jitter);
          st_d              = BK_OUT;
        end
      end
      BK_DECAY: begin
        if (cnt_q < DecaySteps) begin
          cnt_d = cnt_q + 1'b1;
          if (!sat_q) begin
            if (hop_prod > 48'(Sat32)) sat_d = 1'b1;
            acc_d = hop_prod[31:0];
          end
        end else begin
          if (decay_w == 32'd0) begin
            src_we       = 1'b1;
            src_wd.phase = PH_IDLE;
            src_wd.flag  = 1'b0;
            res_d        = fwd_item;
          end else begin
            res_d.action      = ACT_ARM_DECAY;
            res_d.out_source  = src6;
            res_d.delay_ticks = decay_w;
          end
          st_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!o_full_i) begin
          o_push_o = 1'b1;
          st_d     = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BK_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    maxd2_q  <= maxd2_d;
    div_r_q  <= div_r_d;
    div_lo_q <= div_lo_d;
    acc_q    <= acc_d;
    sat_q    <= sat_d;
    if (pop) begin
      cmd_q  <= q_cmd_i;
      idx_q  <= q_idx_i;
      addr_q <= {q_idx_i, q_rem_i};
    end
  end

  // Seen bitmap
  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    if (pop) seen_rd_q <= seen_mem[{q_idx_i, q_rem_i}];
  end

  // Per-source records
  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    if (pop) rec_q <= src_mem[q_idx_i];
  end

endmodule

// ===== rtl/flood_relay_contention_engine.sv =====
// Processing: an arrival that arms the first wait runs the 16-step restoring divider
//   unless the divide is skipped; a first expiry with nonzero hops runs the decay
//   multiplications before its decay arm or forward. Other events need neither.
// The back end holds one event at a time.
// Reset: asynchronous, active low; a clearing pass over all 2**(SrcW + SeqW) seen entries holds full.
module flood_relay_contention_engine #(
  parameter int unsigned NUM_SOURCES    = frce_pkg::NumSourcesDef,
  parameter int unsigned SEQ_WINDOW     = frce_pkg::SeqWindowDef,
  parameter int unsigned DECAY_EXPONENT = frce_pkg::DecayExponentDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  frce_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output frce_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import frce_pkg::*;

  localparam int unsigned SrcW    = $clog2(NUM_SOURCES);
  localparam int unsigned SeqW    = $clog2(SEQ_WINDOW);
  localparam int unsigned CmdBits = $bits(cmd_t) + SrcW + SeqW;

  cfg_t                cfg_q;
  logic                cfg_wr;
  logic [2:0]          reg_idx;
  logic                clearing;
  logic                cq_push, cq_full, cq_empty, cq_pop;
  cmd_t                f_cmd, b_cmd;
  logic [SrcW-1:0]     f_idx, b_idx;
  logic [SeqW-1:0]     f_rem, b_rem;
  logic [CmdBits-1:0]  cq_rd;
  logic                oq_push, oq_full;
  out_item_t           b_item;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_node      <= 6'd1;
      cfg_q.own_x         <= 16'sd0;
      cfg_q.own_y         <= 16'sd0;
      cfg_q.base_interval <= 16'd128;
      cfg_q.near_wait     <= 16'd0;
      cfg_q.far_wait      <= 16'd256;
      cfg_q.reach_meters  <= 15'd50;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OWN_NODE:      cfg_q.own_node      <= pwdata[5:0];
        REG_OWN_X:         cfg_q.own_x         <= pwdata[15:0];
        REG_OWN_Y:         cfg_q.own_y         <= pwdata[15:0];
        REG_BASE_INTERVAL: cfg_q.base_interval <= pwdata[15:0];
        REG_NEAR_WAIT:     cfg_q.near_wait     <= pwdata[15:0];
        REG_FAR_WAIT:      cfg_q.far_wait      <= pwdata[15:0];
        REG_REACH_METERS:  cfg_q.reach_meters  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_OWN_NODE:      prdata = 32'(cfg_q.own_node);
      REG_OWN_X:         prdata = {16'd0, cfg_q.own_x};
      REG_OWN_Y:         prdata = {16'd0, cfg_q.own_y};
      REG_BASE_INTERVAL: prdata = 32'(cfg_q.base_interval);
      REG_NEAR_WAIT:     prdata = 32'(cfg_q.near_wait);
      REG_FAR_WAIT:      prdata = 32'(cfg_q.far_wait);
      REG_REACH_METERS:  prdata = 32'(cfg_q.reach_meters);
      default:           prdata = '0;
    endcase
  end

  // Front: accept and classify
  frce_front #(
    .NUM_SOURCES(NUM_SOURCES),
    .SEQ_WINDOW (SEQ_WINDOW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .hold_i  (clearing),
    .q_full_i(cq_full),
    .q_push_o(cq_push),
    .q_cmd_o (f_cmd),
    .q_idx_o (f_idx),
    .q_rem_o (f_rem)
  );

  // Command queue between front and back
  frce_fifo #(
    .WIDTH(CmdBits),
    .DEPTH(FifoDepthDef)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cq_push),
    .data_i ({f_cmd, f_idx, f_rem}),
    .full_o (cq_full),
    .pop_i  (cq_pop),
    .data_o (cq_rd),
    .empty_o(cq_empty)
  );

  assign {b_cmd, b_idx, b_rem} = cq_rd;

  // Back: table read-modify-write and timer arithmetic
  frce_back #(
    .NUM_SOURCES   (NUM_SOURCES),
    .SEQ_WINDOW    (SEQ_WINDOW),
    .DECAY_EXPONENT(DECAY_EXPONENT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (cq_empty),
    .q_pop_o   (cq_pop),
    .q_cmd_i   (b_cmd),
    .q_idx_i   (b_idx),
    .q_rem_i   (b_rem),
    .o_full_i  (oq_full),
    .o_push_o  (oq_push),
    .o_item_o  (b_item),
    .clearing_o(clearing)
  );

  // Result queue
  frce_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(FifoDepthDef)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (oq_push),
    .data_i (b_item),
    .full_o (oq_full),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

  // No transaction is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> full)
    else $error("transaction accepted while clearing");

  // A result with no action carries no source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.action == ACT_NONE) |-> (out_item_o.out_source == 6'd0))
    else $error("empty action with nonzero source");

  // Only arm actions carry a delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.action != ACT_ARM_FIRST && out_item_o.action != ACT_ARM_DECAY)
    |-> (out_item_o.delay_ticks == 32'd0))
    else $error("delay on a non-arm action");

endmodule
